@@ hw/rtl/vcw_pkg.sv @@
// Package for the velocity command watchdog: field widths, command and
// register codes, reset values and the structs passed between its modules.
// Depends on nothing; every other file of the block uses it.
package vcw_pkg;

    localparam int VEL_W  = 16;
    localparam int LIM_W  = 15;
    localparam int TMO_W  = 16;
    localparam int TIME_W = 32;
    localparam int CODE_W = 32;
    localparam int CMD_W  = 3;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_VELOCITY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEALTH   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MOTION   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CYCLE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd4;

    // Register indexes (word address).
    localparam logic [2:0] REG_LIMIT_X   = 3'd0;
    localparam logic [2:0] REG_LIMIT_Y   = 3'd1;
    localparam logic [2:0] REG_LIMIT_YAW = 3'd2;
    localparam logic [2:0] REG_CMD_TMO   = 3'd3;
    localparam logic [2:0] REG_STATE_TMO = 3'd4;
    localparam logic [2:0] REG_CTRL_CODE = 3'd5;

    // Register reset values.
    localparam logic [LIM_W-1:0]  RST_LIMIT_X   = 15'd8192;
    localparam logic [LIM_W-1:0]  RST_LIMIT_Y   = 15'd4096;
    localparam logic [LIM_W-1:0]  RST_LIMIT_YAW = 15'd8192;
    localparam logic [TMO_W-1:0]  RST_CMD_TMO   = 16'd400;
    localparam logic [TMO_W-1:0]  RST_STATE_TMO = 16'd2500;
    localparam logic [CODE_W-1:0] RST_CTRL_CODE = 32'd17;

    // Result output codes.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DRIVE  = 1'b1;

    // Result sequence that one cycle or stop item produces.
    typedef enum logic [1:0] {
        PLAN_REPORT,
        PLAN_DRIVE,
        PLAN_STOP
    } t_plan;

    typedef struct packed {
        logic [LIM_W-1:0]  limit_x;
        logic [LIM_W-1:0]  limit_y;
        logic [LIM_W-1:0]  limit_yaw;
        logic [TMO_W-1:0]  cmd_tmo;
        logic [TMO_W-1:0]  state_tmo;
        logic [CODE_W-1:0] ctrl_code;
    } t_cfg;

    typedef struct packed {
        t_plan                   plan;
        logic                    ready;
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] yaw;
    } t_bundle;

endpackage

@@ hw/rtl/vcw_if.sv @@
// Channel interfaces of the velocity command watchdog: the input item
// channel and the result channel, each with valid/ready. Depends on vcw_pkg.
interface vcw_item_if;
    logic                             valid;
    logic                             ready;
    logic [vcw_pkg::CMD_W-1:0]        cmd;
    logic [vcw_pkg::TIME_W-1:0]       now_ms;
    logic signed [vcw_pkg::VEL_W-1:0] vel_x;
    logic signed [vcw_pkg::VEL_W-1:0] vel_y;
    logic signed [vcw_pkg::VEL_W-1:0] yaw_rate;
    logic                             values_finite;
    logic                             link_matched;
    logic signed [vcw_pkg::CODE_W-1:0] status_value;

    modport source (output valid, cmd, now_ms, vel_x, vel_y, yaw_rate, values_finite,
                    link_matched, status_value, input ready);
    modport sink (input valid, cmd, now_ms, vel_x, vel_y, yaw_rate, values_finite,
                  link_matched, status_value, output ready);
endinterface

interface vcw_result_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic                             ready_flag;
    logic signed [vcw_pkg::VEL_W-1:0] out_x;
    logic signed [vcw_pkg::VEL_W-1:0] out_y;
    logic signed [vcw_pkg::VEL_W-1:0] out_yaw;
    logic                             last;

    modport source (output valid, kind, ready_flag, out_x, out_y, out_yaw, last,
                    input ready);
    modport sink (input valid, kind, ready_flag, out_x, out_y, out_yaw, last,
                  output ready);
endinterface

@@ hw/rtl/vcw_cfg.sv @@
// APB-style configuration registers of the velocity command watchdog.
// Depends on vcw_pkg for register codes, widths and reset values.
module vcw_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vcw_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [vcw_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [vcw_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output vcw_pkg::t_cfg                      o_cfg
);

    vcw_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes on the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_x   <= vcw_pkg::RST_LIMIT_X;
            r_cfg.limit_y   <= vcw_pkg::RST_LIMIT_Y;
            r_cfg.limit_yaw <= vcw_pkg::RST_LIMIT_YAW;
            r_cfg.cmd_tmo   <= vcw_pkg::RST_CMD_TMO;
            r_cfg.state_tmo <= vcw_pkg::RST_STATE_TMO;
            r_cfg.ctrl_code <= vcw_pkg::RST_CTRL_CODE;
        end else if (wr_en) begin
            unique case (reg_idx)
                vcw_pkg::REG_LIMIT_X:   r_cfg.limit_x   <= pwdata[vcw_pkg::LIM_W-1:0];
                vcw_pkg::REG_LIMIT_Y:   r_cfg.limit_y   <= pwdata[vcw_pkg::LIM_W-1:0];
                vcw_pkg::REG_LIMIT_YAW: r_cfg.limit_yaw <= pwdata[vcw_pkg::LIM_W-1:0];
                vcw_pkg::REG_CMD_TMO:   r_cfg.cmd_tmo   <= pwdata[vcw_pkg::TMO_W-1:0];
                vcw_pkg::REG_STATE_TMO: r_cfg.state_tmo <= pwdata[vcw_pkg::TMO_W-1:0];
                vcw_pkg::REG_CTRL_CODE: r_cfg.ctrl_code <= pwdata[vcw_pkg::CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_idx)
            vcw_pkg::REG_LIMIT_X:   prdata = {17'd0, r_cfg.limit_x};
            vcw_pkg::REG_LIMIT_Y:   prdata = {17'd0, r_cfg.limit_y};
            vcw_pkg::REG_LIMIT_YAW: prdata = {17'd0, r_cfg.limit_yaw};
            vcw_pkg::REG_CMD_TMO:   prdata = {16'd0, r_cfg.cmd_tmo};
            vcw_pkg::REG_STATE_TMO: prdata = {16'd0, r_cfg.state_tmo};
            vcw_pkg::REG_CTRL_CODE: prdata = r_cfg.ctrl_code;
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/vcw_eval.sv @@
// Input register, watchdog state and evaluation of one item of the velocity
// command watchdog. Depends on vcw_pkg and vcw_item_if.
module vcw_eval (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vcw_item_if.sink         i_item,
    input  vcw_pkg::t_cfg    i_cfg,
    input  logic             i_take,
    output logic             o_bundle_valid,
    output vcw_pkg::t_bundle o_bundle
);

    localparam int VW = vcw_pkg::VEL_W;

    // Input register.
    logic                            r_valid;
    logic [vcw_pkg::CMD_W-1:0]       r_cmd;
    logic [vcw_pkg::TIME_W-1:0]      r_now;
    logic signed [VW-1:0]            r_vx;
    logic signed [VW-1:0]            r_vy;
    logic signed [VW-1:0]            r_vyaw;
    logic                            r_finite;
    logic                            r_link;
    logic [vcw_pkg::CODE_W-1:0]      r_status;

    // Watchdog state.
    logic signed [VW-1:0]            r_held_x;
    logic signed [VW-1:0]            r_held_y;
    logic signed [VW-1:0]            r_held_yaw;
    logic [vcw_pkg::TIME_W-1:0]      r_cmd_time;
    logic [vcw_pkg::TIME_W-1:0]      r_rep_time;
    logic                            r_armed;
    logic                            r_health_seen;
    logic                            r_report_seen;
    logic [vcw_pkg::CODE_W-1:0]      r_motion_code;
    logic [vcw_pkg::CODE_W-1:0]      r_health_code;

    logic                            has_res;
    logic                            consume;
    logic                            stopping;
    logic [vcw_pkg::TIME_W-1:0]      rep_age;
    logic [vcw_pkg::TIME_W-1:0]      cmd_age;
    logic                            stale;
    logic                            rdy;
    logic signed [VW-1:0]            clamp_x;
    logic signed [VW-1:0]            clamp_y;
    logic signed [VW-1:0]            clamp_yaw;

    // Symmetric clamp of a signed value to plus or minus an unsigned limit.
    function automatic logic signed [VW-1:0] clamp_sym(
        input logic signed [VW-1:0]           v,
        input logic [vcw_pkg::LIM_W-1:0]      lim
    );
        logic signed [VW:0] v_ext;
        logic signed [VW:0] l_pos;
        logic signed [VW:0] l_neg;
        logic signed [VW:0] res;
        v_ext = {v[VW-1], v};
        l_pos = $signed({2'b00, lim});
        l_neg = -l_pos;
        if (v_ext > l_pos) begin
            res = l_pos;
        end else if (v_ext < l_neg) begin
            res = l_neg;
        end else begin
            res = v_ext;
        end
        return res[VW-1:0];
    endfunction

    assign has_res  = (r_cmd == vcw_pkg::CMD_CYCLE) || (r_cmd == vcw_pkg::CMD_STOP);
    assign consume  = r_valid && (!has_res || i_take);
    assign i_item.ready = !r_valid || consume;

    // Readiness and staleness from the state before this item.
    assign stopping = (r_cmd == vcw_pkg::CMD_STOP);
    assign rep_age  = r_now - r_rep_time;
    assign cmd_age  = r_now - r_cmd_time;
    assign stale    = cmd_age > {16'd0, i_cfg.cmd_tmo};
    assign rdy      = !stopping && r_link && r_report_seen
                      && (rep_age <= {16'd0, i_cfg.state_tmo})
                      && (r_motion_code == i_cfg.ctrl_code)
                      && (!r_health_seen || (r_health_code == '0));

    assign clamp_x   = clamp_sym(r_vx, i_cfg.limit_x);
    assign clamp_y   = clamp_sym(r_vy, i_cfg.limit_y);
    assign clamp_yaw = clamp_sym(r_vyaw, i_cfg.limit_yaw);

    // Result plan handed to the output sequencer.
    always_comb begin
        o_bundle_valid = r_valid && has_res;
        o_bundle.ready = rdy;
        o_bundle.x     = '0;
        o_bundle.y     = '0;
        o_bundle.yaw   = '0;
        if (!r_armed) begin
            o_bundle.plan = vcw_pkg::PLAN_REPORT;
        end else if (stopping || stale) begin
            o_bundle.plan = vcw_pkg::PLAN_STOP;
        end else begin
            o_bundle.plan = vcw_pkg::PLAN_DRIVE;
            if (rdy) begin
                o_bundle.x   = r_held_x;
                o_bundle.y   = r_held_y;
                o_bundle.yaw = r_held_yaw;
            end
        end
    end

    // Input register: payload loads on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
        if (i_item.valid && i_item.ready) begin
            r_cmd    <= i_item.cmd;
            r_now    <= i_item.now_ms;
            r_vx     <= i_item.vel_x;
            r_vy     <= i_item.vel_y;
            r_vyaw   <= i_item.yaw_rate;
            r_finite <= i_item.values_finite;
            r_link   <= i_item.link_matched;
            r_status <= i_item.status_value;
        end
    end

    // State update when the registered item is retired.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_held_yaw    <= '0;
            r_cmd_time    <= '0;
            r_rep_time    <= '0;
            r_armed       <= 1'b0;
            r_health_seen <= 1'b0;
            r_report_seen <= 1'b0;
            r_motion_code <= '0;
            r_health_code <= {{(vcw_pkg::CODE_W-1){1'b0}}, 1'b1};
        end else if (consume) begin
            unique case (r_cmd)
                vcw_pkg::CMD_VELOCITY: begin
                    r_held_x   <= r_finite ? clamp_x : '0;
                    r_held_y   <= r_finite ? clamp_y : '0;
                    r_held_yaw <= r_finite ? clamp_yaw : '0;
                    r_cmd_time <= r_now;
                    r_armed    <= 1'b1;
                end
                vcw_pkg::CMD_HEALTH: begin
                    r_health_code <= r_status;
                    r_health_seen <= 1'b1;
                end
                vcw_pkg::CMD_MOTION: begin
                    r_motion_code <= r_status;
                    r_rep_time    <= r_now;
                    r_report_seen <= 1'b1;
                end
                vcw_pkg::CMD_CYCLE, vcw_pkg::CMD_STOP: begin
                    if (r_armed && (stopping || stale)) begin
                        r_armed <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/vcw_emit.sv @@
// Result sequencer of the velocity command watchdog: holds one result plan
// and sends its one to three transactions. Depends on vcw_pkg, vcw_result_if.
module vcw_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_bundle_valid,
    input  vcw_pkg::t_bundle i_bundle,
    output logic             o_take,
    vcw_result_if.source     o_res
);

    logic             r_busy;
    logic [1:0]       r_idx;
    vcw_pkg::t_bundle r_bundle;
    logic             is_last;
    logic             done;

    // Result fields for the current position in the sequence.
    always_comb begin
        o_res.kind       = vcw_pkg::KIND_DRIVE;
        o_res.ready_flag = 1'b0;
        o_res.out_x      = '0;
        o_res.out_y      = '0;
        o_res.out_yaw    = '0;
        unique case (r_idx)
            2'd0: begin
                o_res.kind       = vcw_pkg::KIND_REPORT;
                o_res.ready_flag = r_bundle.ready;
                is_last          = (r_bundle.plan == vcw_pkg::PLAN_REPORT);
            end
            2'd1: begin
                o_res.out_x   = r_bundle.x;
                o_res.out_y   = r_bundle.y;
                o_res.out_yaw = r_bundle.yaw;
                is_last       = (r_bundle.plan == vcw_pkg::PLAN_DRIVE);
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
    end

    assign o_res.valid = r_busy;
    assign o_res.last  = is_last;
    assign done        = r_busy && o_res.ready && is_last;
    assign o_take      = !r_busy || done;

    // Sequence position; a new plan loads as the old one finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_take) begin
            r_busy <= i_bundle_valid;
            r_idx  <= 2'd0;
        end else if (o_res.ready) begin
            r_idx <= r_idx + 2'd1;
        end
        if (o_take && i_bundle_valid) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

@@ hw/rtl/velocity_command_watchdog.sv @@
// Velocity command watchdog top level. An accepted item is held in the input
// register; its result plan loads into the sequencer register, which sends the
// results. Report and command items retire without the result port; a cycle or
// stop item waits for the sequencer, which then sends its one to three results.
// Reset (synchronous, active low) disarms the path, clears held state and
// restores the register defaults.
module velocity_command_watchdog (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vcw_item_if.sink                       i_item,
    vcw_result_if.source                   o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vcw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [vcw_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [vcw_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    vcw_pkg::t_cfg    cfg;
    vcw_pkg::t_bundle bundle;
    logic             bundle_valid;
    logic             take;

    // Configuration registers.
    vcw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Item register, state and evaluation.
    vcw_eval u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cfg          (cfg),
        .i_take         (take),
        .o_bundle_valid (bundle_valid),
        .o_bundle       (bundle)
    );

    // Result sequencing.
    vcw_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle_valid (bundle_valid),
        .i_bundle       (bundle),
        .o_take         (take),
        .o_res          (o_res)
    );

endmodule

@@ bench/tb_velocity_command_watchdog.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for velocity_command_watchdog: directed and random
// transactions checked against a behavioral predictor, with APB register writes.
// Depends on vcw_pkg, the vcw_item_if/vcw_result_if interfaces and the RTL top.
module tb_velocity_command_watchdog;
    import vcw_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [TIME_W-1:0]       now_ms;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] yaw_rate;
        logic                    finite;
        logic                    link;
        logic [CODE_W-1:0]       status;
    } t_velocity_item;

    typedef struct {
        logic                    kind;
        logic                    ready_flag;
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] yaw;
        logic                    last;
    } t_drive_output;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    vcw_item_if   item_ch();
    vcw_result_if res_ch();

    velocity_command_watchdog u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a copy of the registers and of the held command path.
    t_cfg                    model_cfg;
    logic signed [VEL_W-1:0] held_x, held_y, held_yaw;
    logic [TIME_W-1:0]       command_stamp, report_stamp;
    logic                    path_armed, health_seen, report_seen;
    logic [CODE_W-1:0]       motion_code, health_code;

    t_drive_output pending_outputs[$];
    int            fault_count = 0;
    int            cycle_count = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            hold_request = 0;
    int            hold_left = 0;
    logic [TIME_W-1:0] wall_ms = 32'd0;

    always #2 i_clk = ~i_clk;

    task automatic note_fault(input string msg);
        if (fault_count < REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
        fault_count++;
    endtask

    function automatic void queue_output(input logic kind, input logic rdy,
                                         input logic signed [VEL_W-1:0] x,
                                         input logic signed [VEL_W-1:0] y,
                                         input logic signed [VEL_W-1:0] yaw,
                                         input logic last);
        t_drive_output o;
        o.kind = kind;
        o.ready_flag = rdy;
        o.x = x;
        o.y = y;
        o.yaw = yaw;
        o.last = last;
        pending_outputs.push_back(o);
    endfunction

    // Symmetric clamp of a signed request to plus or minus the limit.
    function automatic logic signed [VEL_W-1:0] clamp_axis(input logic signed [VEL_W-1:0] v,
                                                         input logic [LIM_W-1:0] lim);
        int l;
        int s;
        int neg;
        l = lim;
        s = v;
        neg = -l;
        if (s > l) begin
            return l[VEL_W-1:0];
        end
        if (s < neg) begin
            return neg[VEL_W-1:0];
        end
        return v;
    endfunction

    // Updates the predictor for one accepted transaction and queues its results.
    function automatic void watchdog_predict(input t_velocity_item it);
        logic [TIME_W-1:0] report_age;
        logic [TIME_W-1:0] cmd_age;
        logic              stopping;
        logic              rdy;
        case (it.cmd)
            CMD_VELOCITY: begin
                if (it.finite) begin
                    held_x = clamp_axis(it.vel_x, model_cfg.limit_x);
                    held_y = clamp_axis(it.vel_y, model_cfg.limit_y);
                    held_yaw = clamp_axis(it.yaw_rate, model_cfg.limit_yaw);
                end else begin
                    held_x = '0;
                    held_y = '0;
                    held_yaw = '0;
                end
                command_stamp = it.now_ms;
                path_armed = 1'b1;
            end
            CMD_HEALTH: begin
                health_code = it.status;
                health_seen = 1'b1;
            end
            CMD_MOTION: begin
                motion_code = it.status;
                report_stamp = it.now_ms;
                report_seen = 1'b1;
            end
            CMD_CYCLE, CMD_STOP: begin
                stopping = (it.cmd == CMD_STOP);
                report_age = it.now_ms - report_stamp;
                cmd_age = it.now_ms - command_stamp;
                rdy = !stopping && it.link && report_seen
                      && (report_age <= TIME_W'(model_cfg.state_tmo))
                      && (motion_code == model_cfg.ctrl_code)
                      && (!health_seen || health_code == '0);
                if (!path_armed) begin
                    queue_output(KIND_REPORT, rdy, '0, '0, '0, 1'b1);
                end else begin
                    queue_output(KIND_REPORT, rdy, '0, '0, '0, 1'b0);
                    if (stopping || cmd_age > TIME_W'(model_cfg.cmd_tmo)) begin
                        // Stale or stopped path: disarm and send two zero commands.
                        path_armed = 1'b0;
                        queue_output(KIND_DRIVE, 1'b0, '0, '0, '0, 1'b0);
                        queue_output(KIND_DRIVE, 1'b0, '0, '0, '0, 1'b1);
                    end else if (rdy) begin
                        queue_output(KIND_DRIVE, 1'b0, held_x, held_y, held_yaw, 1'b1);
                    end else begin
                        queue_output(KIND_DRIVE, 1'b0, '0, '0, '0, 1'b1);
                    end
                end
            end
            default: begin
                // Unknown codes are dropped without a trace.
            end
        endcase
    endfunction

    function automatic t_velocity_item mk_item(input logic [CMD_W-1:0] cmd,
                                               input logic [TIME_W-1:0] now,
                                               input logic signed [VEL_W-1:0] x,
                                               input logic signed [VEL_W-1:0] y,
                                               input logic signed [VEL_W-1:0] yaw,
                                               input logic finite, input logic link,
                                               input logic [CODE_W-1:0] status);
        t_velocity_item it;
        it.cmd = cmd;
        it.now_ms = now;
        it.vel_x = x;
        it.vel_y = y;
        it.yaw_rate = yaw;
        it.finite = finite;
        it.link = link;
        it.status = status;
        return it;
    endfunction

    // Half the requests span the full range, half sit around typical limits.
    function automatic logic signed [VEL_W-1:0] rand_velocity();
        int v;
        if ($urandom_range(1) == 1) begin
            return VEL_W'($urandom);
        end
        v = $urandom_range(16383) - 8192;
        return v[VEL_W-1:0];
    endfunction

    // Random transaction with a time base that mostly creeps forward.
    function automatic t_velocity_item random_item();
        t_velocity_item it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            wall_ms = wall_ms;
        end else if (pick < 75) begin
            wall_ms += $urandom_range(1, 60);
        end else if (pick < 90) begin
            wall_ms += $urandom_range(100, 1000);
        end else if (pick < 94) begin
            wall_ms += $urandom_range(1000, 4000);
        end else if (pick < 97) begin
            wall_ms -= $urandom_range(1, 500);
        end else begin
            wall_ms = $urandom;
        end
        it = mk_item(CMD_CYCLE, wall_ms, rand_velocity(), rand_velocity(), rand_velocity(),
                     ($urandom_range(99) < 90), ($urandom_range(99) < 85), $urandom);
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.cmd = CMD_VELOCITY;
        end else if (pick < 40) begin
            it.cmd = CMD_HEALTH;
            if ($urandom_range(99) < 70) begin
                it.status = '0;
            end
        end else if (pick < 55) begin
            it.cmd = CMD_MOTION;
            if ($urandom_range(99) < 75) begin
                it.status = model_cfg.ctrl_code;
            end
        end else if (pick < 88) begin
            it.cmd = CMD_CYCLE;
        end else if (pick < 95) begin
            it.cmd = CMD_STOP;
        end else begin
            it.cmd = CMD_W'($urandom_range(CMD_STOP + 1, 7));
        end
        return it;
    endfunction

    // Offers one transaction, with random idle cycles first, and predicts on acceptance.
    task automatic send_item(input t_velocity_item it);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) begin
                @(posedge i_clk);
            end
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= it.cmd;
        item_ch.now_ms <= it.now_ms;
        item_ch.vel_x <= it.vel_x;
        item_ch.vel_y <= it.vel_y;
        item_ch.yaw_rate <= it.yaw_rate;
        item_ch.values_finite <= it.finite;
        item_ch.link_matched <= it.link;
        item_ch.status_value <= it.status;
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
        watchdog_predict(it);
    endtask

    task automatic run_random_items(input int count);
        t_velocity_item it;
        int done;
        done = 0;
        while (done < count) begin
            it = random_item();
            if (it.cmd <= CMD_STOP) begin
                done++;
            end
            send_item(it);
        end
    endtask

    // Lets every expected result come out, then lets the bench settle before the check.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        item_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_outputs.size() != 0) begin
            note_fault($sformatf("%0d expected results never arrived",
                                 pending_outputs.size()));
            pending_outputs.delete();
        end
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_register(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] stored;
        stored = '0;
        case (idx)
            REG_LIMIT_X: begin
                model_cfg.limit_x = value[LIM_W-1:0];
                stored[LIM_W-1:0] = value[LIM_W-1:0];
            end
            REG_LIMIT_Y: begin
                model_cfg.limit_y = value[LIM_W-1:0];
                stored[LIM_W-1:0] = value[LIM_W-1:0];
            end
            REG_LIMIT_YAW: begin
                model_cfg.limit_yaw = value[LIM_W-1:0];
                stored[LIM_W-1:0] = value[LIM_W-1:0];
            end
            REG_CMD_TMO: begin
                model_cfg.cmd_tmo = value[TMO_W-1:0];
                stored[TMO_W-1:0] = value[TMO_W-1:0];
            end
            REG_STATE_TMO: begin
                model_cfg.state_tmo = value[TMO_W-1:0];
                stored[TMO_W-1:0] = value[TMO_W-1:0];
            end
            REG_CTRL_CODE: begin
                model_cfg.ctrl_code = value;
                stored = value;
            end
            default: begin
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata !== stored) begin
            note_fault($sformatf("register %0d read back %h, expected %h", idx, prdata, stored));
        end
        // Bus returns to idle before the next transaction.
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_registers(input logic [CFG_DATA_W-1:0] lim_x,
                                       input logic [CFG_DATA_W-1:0] lim_y,
                                       input logic [CFG_DATA_W-1:0] lim_yaw,
                                       input logic [CFG_DATA_W-1:0] cmd_tmo,
                                       input logic [CFG_DATA_W-1:0] state_tmo,
                                       input logic [CFG_DATA_W-1:0] ctrl_code);
        wait_for_drain();
        write_register(REG_LIMIT_X, lim_x);
        write_register(REG_LIMIT_Y, lim_y);
        write_register(REG_LIMIT_YAW, lim_yaw);
        write_register(REG_CMD_TMO, cmd_tmo);
        write_register(REG_STATE_TMO, state_tmo);
        write_register(REG_CTRL_CODE, ctrl_code);
    endtask

    // Hand-picked transactions at the reset register values.
    task automatic test_directed_cases();
        int c;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // Nothing armed yet: only readiness reports.
        send_item(mk_item(CMD_CYCLE, 32'd1000, '0, '0, '0, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_STOP, 32'd1000, '0, '0, '0, 1'b1, 1'b1, '0));
        // Ready while health was never reported; requests at the extremes clamp.
        send_item(mk_item(CMD_MOTION, 32'd1000, '0, '0, '0, 1'b1, 1'b1, 32'd17));
        send_item(mk_item(CMD_VELOCITY, 32'd1000, 16'sh7fff, 16'sh8000, 16'sh8000,
                          1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'd1010, '0, '0, '0, 1'b1, 1'b1, '0));
        // Bad health blocks readiness, good health restores it, no link blocks it.
        send_item(mk_item(CMD_HEALTH, 32'd1010, '0, '0, '0, 1'b1, 1'b1, 32'd5));
        send_item(mk_item(CMD_CYCLE, 32'd1015, '0, '0, '0, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_HEALTH, 32'd1015, '0, '0, '0, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'd1020, '0, '0, '0, 1'b1, 1'b0, '0));
        // A non-finite request zeroes the held command but still arms.
        send_item(mk_item(CMD_VELOCITY, 32'd1030, 16'sd1234, -16'sd1234, 16'sd77,
                          1'b0, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'd1040, '0, '0, '0, 1'b1, 1'b1, '0));
        // Command age exactly at the timeout passes; one more ms goes stale.
        send_item(mk_item(CMD_VELOCITY, 32'd1050, -16'sd100, 16'sd100, '0, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'd1450, '0, '0, '0, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'd1451, '0, '0, '0, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'd1460, '0, '0, '0, 1'b1, 1'b1, '0));
        // Stop on an armed path.
        send_item(mk_item(CMD_VELOCITY, 32'd1470, 16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_STOP, 32'd1470, '0, '0, '0, 1'b1, 1'b1, '0));
        // Unknown codes do nothing.
        for (c = CMD_STOP + 1; c < 8; c++) begin
            send_item(mk_item(CMD_W'(c), $urandom, 16'sh7fff, 16'sh8000, 16'sh7fff,
                              1'b1, 1'b1, $urandom));
        end
        // Report age exactly at the state timeout is still fresh.
        send_item(mk_item(CMD_MOTION, 32'd5000, '0, '0, '0, 1'b1, 1'b1, 32'd17));
        send_item(mk_item(CMD_VELOCITY, 32'd7400, 16'sd321, 16'sd222, -16'sd111,
                          1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'd7500, '0, '0, '0, 1'b1, 1'b1, '0));
        // Time wraps past zero; then a stamp that looks like it lies in the future.
        send_item(mk_item(CMD_MOTION, 32'hffff_fff0, '0, '0, '0, 1'b1, 1'b1, 32'd17));
        send_item(mk_item(CMD_VELOCITY, 32'hffff_fff0, 16'sd300, -16'sd300, 16'sd300,
                          1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'h0000_0010, '0, '0, '0, 1'b1, 1'b1, '0));
        send_item(mk_item(CMD_CYCLE, 32'hffff_ffef, '0, '0, '0, 1'b1, 1'b1, '0));
        wait_for_drain();
    endtask

    // Random traffic under extreme and random register settings.
    task automatic test_register_extremes();
        src_idle_pct = 8;
        sink_stall_pct = 8;
        wall_ms = $urandom;
        write_all_registers('0, '0, '0, '0, '0, 32'h8000_0000);
        run_random_items(30);
        write_all_registers(32'h7fff, 32'h7fff, 32'h7fff, 32'hffff, 32'hffff, 32'h7fff_ffff);
        run_random_items(30);
        write_all_registers($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_random_items(30);
        wait_for_drain();
    endtask

    // Random traffic at the default settings under each idling pattern.
    task automatic test_idle_phases();
        write_all_registers(RST_LIMIT_X, RST_LIMIT_Y, RST_LIMIT_YAW, RST_CMD_TMO,
                            RST_STATE_TMO, RST_CTRL_CODE);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random_items(45);
        src_idle_pct = 66;
        run_random_items(45);
        src_idle_pct = 0;
        sink_stall_pct = 66;
        run_random_items(45);
        src_idle_pct = 8;
        sink_stall_pct = 8;
        run_random_items(45);
        wait_for_drain();
    endtask

    // Result port held off for a long stretch while cycle transactions keep coming.
    task automatic test_output_backpressure();
        int n;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        wall_ms += 100;
        send_item(mk_item(CMD_MOTION, wall_ms, '0, '0, '0, 1'b1, 1'b1, model_cfg.ctrl_code));
        send_item(mk_item(CMD_HEALTH, wall_ms, '0, '0, '0, 1'b1, 1'b1, '0));
        hold_request = 150;
        for (n = 0; n < 30; n++) begin
            wall_ms += 2;
            if (n % 8 == 0) begin
                send_item(mk_item(CMD_VELOCITY, wall_ms, rand_velocity(), rand_velocity(),
                                  rand_velocity(), 1'b1, 1'b1, '0));
            end else if (n == 21) begin
                send_item(mk_item(CMD_STOP, wall_ms, '0, '0, '0, 1'b1, 1'b1, '0));
            end else begin
                send_item(mk_item(CMD_CYCLE, wall_ms, '0, '0, '0, 1'b1, 1'b1, '0));
            end
        end
        wait_for_drain();
    endtask

    // Result port ready: random stalls, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compares every result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_drive_output act;
        t_drive_output exp_out;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            act.kind = res_ch.kind;
            act.ready_flag = res_ch.ready_flag;
            act.x = res_ch.out_x;
            act.y = res_ch.out_y;
            act.yaw = res_ch.out_yaw;
            act.last = res_ch.last;
            if (pending_outputs.size() == 0) begin
                note_fault($sformatf({"unexpected result kind=%0d rdy=%0d x=%0d ",
                                      "y=%0d yaw=%0d last=%0d"},
                                     act.kind, act.ready_flag, act.x, act.y, act.yaw,
                                     act.last));
            end else begin
                exp_out = pending_outputs.pop_front();
                if (act.kind !== exp_out.kind || act.ready_flag !== exp_out.ready_flag
                        || act.x !== exp_out.x || act.y !== exp_out.y
                        || act.yaw !== exp_out.yaw || act.last !== exp_out.last) begin
                    note_fault($sformatf({"result mismatch: expected kind=%0d rdy=%0d x=%0d ",
                                          "y=%0d yaw=%0d last=%0d, got kind=%0d rdy=%0d ",
                                          "x=%0d y=%0d yaw=%0d last=%0d"},
                                         exp_out.kind, exp_out.ready_flag, exp_out.x,
                                         exp_out.y, exp_out.yaw, exp_out.last, act.kind,
                                         act.ready_flag, act.x, act.y, act.yaw, act.last));
                end
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_velocity_command_watchdog: errors");
            $finish;
        end
    end

    initial begin
        // Known values on every input before the first edge.
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_VELOCITY;
        item_ch.now_ms = '0;
        item_ch.vel_x = '0;
        item_ch.vel_y = '0;
        item_ch.yaw_rate = '0;
        item_ch.values_finite = 1'b0;
        item_ch.link_matched = 1'b0;
        item_ch.status_value = '0;
        res_ch.ready = 1'b0;

        // Predictor starts from the reset state.
        model_cfg.limit_x = RST_LIMIT_X;
        model_cfg.limit_y = RST_LIMIT_Y;
        model_cfg.limit_yaw = RST_LIMIT_YAW;
        model_cfg.cmd_tmo = RST_CMD_TMO;
        model_cfg.state_tmo = RST_STATE_TMO;
        model_cfg.ctrl_code = RST_CTRL_CODE;
        held_x = '0;
        held_y = '0;
        held_yaw = '0;
        command_stamp = '0;
        report_stamp = '0;
        path_armed = 1'b0;
        health_seen = 1'b0;
        report_seen = 1'b0;
        motion_code = '0;
        health_code = 32'd1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_extremes();
        test_idle_phases();
        test_output_backpressure();
        wait_for_drain();

        if (fault_count == 0) begin
            $display("tb_velocity_command_watchdog: clean");
        end else begin
            $display("tb_velocity_command_watchdog: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/vcw_pkg.sv
hw/rtl/vcw_if.sv
hw/rtl/vcw_cfg.sv
hw/rtl/vcw_eval.sv
hw/rtl/vcw_emit.sv
hw/rtl/velocity_command_watchdog.sv
bench/tb_velocity_command_watchdog.sv
